>>> rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg: shared types and constants for the RGB to HSV pixel core
// Pixel structs, hue sector codes, datapath widths and the divider stage record.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int CH_W       = 8;                // channel width
	localparam int NUM_W      = 11;               // hue numerator, up to 6*255
	localparam int HREM_W     = NUM_W + CH_W;     // 255 * hue numerator
	localparam int SREM_W     = CH_W + CH_W;      // 255 * chroma
	localparam int QUO_W      = 8;                // quotient bits of both divides
	localparam int DIV_STAGES = QUO_W;            // one quotient bit per stage

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_pix_t;

	typedef struct packed {
		logic [CH_W-1:0] hue_byte;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] brightness;
	} hsv_pix_t;

	// which channel is largest, red split by the sign of green - blue
	typedef enum logic [1:0] {
		SEC_RED_UP,
		SEC_RED_WRAP,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [HREM_W-1:0] hrem;
		logic [NUM_W-1:0]  hden;
		logic [QUO_W-1:0]  hquo;
		logic [SREM_W-1:0] srem;
		logic [CH_W-1:0]   sden;
		logic [QUO_W-1:0]  squo;
		logic [CH_W-1:0]   brightness;
	} div_stage_t;

endpackage

>>> rtl/rgb_to_hsv_pixel_core.sv
// Throughput: one pixel per clock while hsv_ready does not hold the output;
// the two restoring dividers retire one quotient bit per stage over eight
// stages, so they never hold an item back. Stages advance independently, so
// bubbles collapse while the output stalls.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_core
// Pipelined 8-bit RGB to HSV conversion with exact truncating division.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_core
	import hsv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rgb_valid,
	output logic     rgb_ready,
	input  rgb_pix_t rgb,
	output logic     hsv_valid,
	input  logic     hsv_ready,
	output hsv_pix_t hsv
);

	// stage 1: max, min, sector
	logic            valid_s1;
	logic [CH_W-1:0] red_s1, green_s1, blue_s1, hi_s1, lo_s1;
	sector_t         sec_s1;

	// stage 2: chroma and hue numerator
	logic             valid_s2;
	logic             grey_s2;
	logic [CH_W-1:0]  chroma_s2, hi_s2;
	logic [NUM_W-1:0] num_s2;

	// div_s[0] is stage 3 (scaled operands), div_s[1..8] are stages 4..11
	logic                 div_valid_s [DIV_STAGES+1];
	div_stage_t           div_s       [DIV_STAGES+1];
	div_stage_t           div_nxt     [DIV_STAGES+1];
	logic                 div_adv     [DIV_STAGES+1];

	logic adv_s1, adv_s2;

	// stage 1 combinational
	logic            r_max, g_max;
	logic [CH_W-1:0] hi_c, lo_c;
	sector_t         sec_c;

	// stage 2 combinational
	logic [CH_W-1:0]  chroma_c;
	logic [NUM_W-1:0] num_c;

	function automatic logic [NUM_W-1:0] chroma_s1_x6(input logic [CH_W-1:0] c);
		chroma_s1_x6 = (NUM_W'(c) << 2) + (NUM_W'(c) << 1);
	endfunction

	// ---------------- flow control ----------------
	always_comb begin
		div_adv[DIV_STAGES] = !div_valid_s[DIV_STAGES] || hsv_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--)
			div_adv[k] = !div_valid_s[k] || div_adv[k+1];
		adv_s2 = !valid_s2 || div_adv[0];
		adv_s1 = !valid_s1 || adv_s2;
	end

	assign rgb_ready = adv_s1;

	// ---------------- stage 1 ----------------
	always_comb begin
		// ties: red beats green, green beats blue
		r_max = (rgb.red >= rgb.green) && (rgb.red >= rgb.blue);
		g_max = !r_max && (rgb.green >= rgb.blue);
		if (r_max)
			hi_c = rgb.red;
		else if (g_max)
			hi_c = rgb.green;
		else
			hi_c = rgb.blue;
		lo_c = rgb.red;
		if (rgb.green < lo_c)
			lo_c = rgb.green;
		if (rgb.blue < lo_c)
			lo_c = rgb.blue;
		if (r_max)
			sec_c = (rgb.green >= rgb.blue) ? SEC_RED_UP : SEC_RED_WRAP;
		else if (g_max)
			sec_c = SEC_GREEN;
		else
			sec_c = SEC_BLUE;
	end

	// ---------------- stage 2 ----------------
	always_comb begin
		chroma_c = hi_s1 - lo_s1;
		unique case (sec_s1)
			SEC_RED_UP:
				num_c = NUM_W'(green_s1) - NUM_W'(blue_s1);
			SEC_RED_WRAP:
				num_c = (NUM_W'(chroma_s1_x6(chroma_c)))
					- (NUM_W'(blue_s1) - NUM_W'(green_s1));
			SEC_GREEN:
				num_c = {NUM_W'(chroma_c) << 1} + NUM_W'(blue_s1) - NUM_W'(red_s1);
			SEC_BLUE:
				num_c = {NUM_W'(chroma_c) << 2} + NUM_W'(red_s1) - NUM_W'(green_s1);
			default:
				num_c = '0;
		endcase
	end

	// ---------------- stage 3 and divider stages ----------------
	always_comb begin
		div_stage_t        src;
		logic [HREM_W-1:0] hsh;
		logic [SREM_W-1:0] ssh;

		// stage 3: scale by 255 as (x << 8) - x; grey pixels divide 0 by 1
		div_nxt[0].hrem       = (HREM_W'(num_s2) << CH_W) - HREM_W'(num_s2);
		div_nxt[0].hden       = grey_s2 ? NUM_W'(1) : chroma_s1_x6(chroma_s2);
		div_nxt[0].hquo       = '0;
		div_nxt[0].srem       = (SREM_W'(chroma_s2) << CH_W) - SREM_W'(chroma_s2);
		div_nxt[0].sden       = grey_s2 ? CH_W'(1) : hi_s2;
		div_nxt[0].squo       = '0;
		div_nxt[0].brightness = hi_s2;

		// restoring division, MSB first, one quotient bit per stage
		for (int k = 0; k < DIV_STAGES; k++) begin
			src = div_s[k];
			hsh = HREM_W'(src.hden) << (DIV_STAGES - 1 - k);
			ssh = SREM_W'(src.sden) << (DIV_STAGES - 1 - k);
			div_nxt[k+1] = src;
			if (src.hrem >= hsh) begin
				div_nxt[k+1].hrem = src.hrem - hsh;
				div_nxt[k+1].hquo[DIV_STAGES-1-k] = 1'b1;
			end
			if (src.srem >= ssh) begin
				div_nxt[k+1].srem = src.srem - ssh;
				div_nxt[k+1].squo[DIV_STAGES-1-k] = 1'b1;
			end
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			for (int k = 0; k <= DIV_STAGES; k++)
				div_valid_s[k] <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= rgb_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (div_adv[0])
				div_valid_s[0] <= valid_s2;
			for (int k = 1; k <= DIV_STAGES; k++)
				if (div_adv[k])
					div_valid_s[k] <= div_valid_s[k-1];
		end
	end

	// ---------------- data registers ----------------
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			red_s1   <= rgb.red;
			green_s1 <= rgb.green;
			blue_s1  <= rgb.blue;
			hi_s1    <= hi_c;
			lo_s1    <= lo_c;
			sec_s1   <= sec_c;
		end
		if (adv_s2) begin
			grey_s2   <= (hi_s1 == lo_s1);
			chroma_s2 <= chroma_c;
			hi_s2     <= hi_s1;
			num_s2    <= num_c;
		end
		for (int k = 0; k <= DIV_STAGES; k++)
			if (div_adv[k])
				div_s[k] <= div_nxt[k];
	end

	assign hsv_valid       = div_valid_s[DIV_STAGES];
	assign hsv.hue_byte    = div_s[DIV_STAGES].hquo;
	assign hsv.saturation  = div_s[DIV_STAGES].squo;
	assign hsv.brightness  = div_s[DIV_STAGES].brightness;

	// ---------------- assertions ----------------
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hsv.hue_byte != 8'hFF)
		else $error("hue quotient out of range");

	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> div_s[DIV_STAGES].hrem < HREM_W'(div_s[DIV_STAGES].hden))
		else $error("hue remainder not below divisor");

	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> div_s[DIV_STAGES].srem < SREM_W'(div_s[DIV_STAGES].sden))
		else $error("saturation remainder not below divisor");

	a_num_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !grey_s2) |-> num_s2 < chroma_s1_x6(chroma_s2))
		else $error("hue numerator exceeds six times chroma");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s2) |=> (valid_s1 && $stable(hi_s1) && $stable(sec_s1)))
		else $error("stage 1 changed while stalled");

endmodule
